// ----- rtl/text_console_cursor_engine_macros.svh -----
// Assertion macros used by the text console cursor engine back end.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS
// Condition a implies condition b in the same cycle.
`define TCCE_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("text console cursor engine: assertion failed");
// Condition a implies condition b in the following cycle.
`define TCCE_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("text console cursor engine: assertion failed");
`else
`define TCCE_ASSERT_SAME(label, clk, rst, a, b)
`define TCCE_ASSERT_NEXT(label, clk, rst, a, b)
`endif

`endif

// ----- rtl/tcce_pkg.sv -----
// Shared types and constants of the text console cursor engine.
// No dependencies; used by the front, back and top level.
package tcce_pkg;

   localparam logic [1:0] KIND_PUT   = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CHAR_RETURN    = 8'd13;
   localparam logic [7:0] CHAR_TAB       = 8'd9;
   localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
   localparam logic [7:0] CHAR_BLANK     = 8'h20;

   localparam logic [7:0] RESET_COLOR = 8'h07;

   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_RETURN,
      OP_TAB,
      OP_BACKSPACE,
      OP_CLEAR,
      OP_READ,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } cmd_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [15:0] cell_data;
      logic        scrolled;
   } rsp_type;

endpackage

// ----- rtl/tcce_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/tcce_queue.sv -----
// Small first-in first-out queue of register slots with show-ahead head.
// No dependencies; carries command and result transactions.
module tcce_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head
);

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/tcce_front.sv -----
// Front end: accepts input transactions, classifies them into commands
// and queues them for the back end. Depends on tcce_pkg and tcce_queue.
module tcce_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             hold,
   input  logic             req_push,
   output logic             req_full,
   input  logic [1:0]       req_kind,
   input  logic [7:0]       req_char_code,
   input  logic [10:0]      req_cell_index,
   output tcce_pkg::cmd_type cmd_head,
   output logic             cmd_valid,
   input  logic             cmd_pop
);

   tcce_pkg::cmd_type cmd_new;
   logic              q_full, q_empty, q_push;
   logic [$bits(tcce_pkg::cmd_type)-1:0] q_head;

   always_comb begin
      cmd_new.char_code  = req_char_code;
      cmd_new.cell_index = req_cell_index;
      unique case (req_kind)
         tcce_pkg::KIND_PUT: begin
            unique case (req_char_code)
               tcce_pkg::CHAR_NEWLINE:   cmd_new.op = tcce_pkg::OP_NEWLINE;
               tcce_pkg::CHAR_RETURN:    cmd_new.op = tcce_pkg::OP_RETURN;
               tcce_pkg::CHAR_TAB:       cmd_new.op = tcce_pkg::OP_TAB;
               tcce_pkg::CHAR_BACKSPACE: cmd_new.op = tcce_pkg::OP_BACKSPACE;
               default:                  cmd_new.op = tcce_pkg::OP_PUT;
            endcase
         end
         tcce_pkg::KIND_CLEAR: cmd_new.op = tcce_pkg::OP_CLEAR;
         tcce_pkg::KIND_READ:  cmd_new.op = tcce_pkg::OP_READ;
         default:              cmd_new.op = tcce_pkg::OP_NONE;
      endcase
   end

   // hold off the producer while the back end clears the store after reset
   assign req_full = q_full || hold;
   assign q_push   = req_push && !req_full;

   tcce_queue #(
      .WIDTH($bits(tcce_pkg::cmd_type)),
      .DEPTH(tcce_pkg::CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (cmd_new),
      .full      (q_full),
      .pop       (cmd_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   assign cmd_head  = tcce_pkg::cmd_type'(q_head);
   assign cmd_valid = !q_empty;

endmodule

// ----- rtl/tcce_back.sv -----
// Back end: executes queued commands against the cell store and cursor,
// runs the blanking sweeps and emits results. Depends on tcce_pkg, tcce_ram and the macros header.
`include "text_console_cursor_engine_macros.svh"

module tcce_back #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic              clock,
   input  logic              reset,
   input  tcce_pkg::cmd_type cmd_head,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   input  logic              csr_write,
   input  logic [7:0]        csr_data,
   input  logic              rsp_full,
   output logic              rsp_push,
   output tcce_pkg::rsp_type rsp_data,
   output logic              init_busy
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(COLUMNS + 8);
   localparam int RW    = $clog2(ROWS + 1);
   localparam int IW    = (AW > 11) ? AW : 11;
   localparam int SW    = IW + 1;

   localparam logic [AW:0]   CELLS_A = (AW + 1)'(CELLS);
   localparam logic [AW:0]   COLS_A  = (AW + 1)'(COLUMNS);
   localparam logic [SW-1:0] CELLS_S = SW'(CELLS);
   localparam logic [CW-1:0] COLS_C  = CW'(COLUMNS);
   localparam logic [RW-1:0] ROWS_R  = RW'(ROWS);

   typedef enum logic [1:0] {
      ST_INIT,
      ST_IDLE,
      ST_SWEEP,
      ST_RESPOND
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [AW-1:0]     row_base_ff, row_base_in;
   logic [AW-1:0]     top_base_ff, top_base_in;
   logic [7:0]        color_ff, color_in;
   logic [AW-1:0]     sweep_cnt_ff, sweep_cnt_in;
   logic [AW-1:0]     sweep_last_ff, sweep_last_in;
   logic [AW-1:0]     sweep_start_ff, sweep_start_in;
   logic [7:0]        sweep_color_ff, sweep_color_in;
   logic              rd_valid_ff, rd_valid_in;
   tcce_pkg::rsp_type res_ff, res_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [15:0]       wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [15:0]       rd_data;

   logic [CW-1:0]     col_nx;
   logic [RW-1:0]     row_nx;
   logic [RW-1:0]     row_inc;
   logic              advance;
   logic              scroll;
   logic [SW-1:0]     rd_sum;
   logic              sweep_done;

   // physical start of the row below, wrapping around the circular store
   function automatic logic [AW-1:0] next_row_start(input logic [AW-1:0] start);
      logic [AW:0] sum;
      sum = {1'b0, start} + COLS_A;
      if (sum >= CELLS_A) begin
         sum = sum - CELLS_A;
      end
      return sum[AW-1:0];
   endfunction

   assign cmd_pop    = (state_ff == ST_IDLE) && cmd_valid && !rsp_full;
   assign sweep_done = (sweep_cnt_ff == sweep_last_ff);
   assign init_busy  = (state_ff == ST_INIT);

   // cursor step for character commands
   always_comb begin
      col_nx  = col_ff;
      advance = 1'b0;
      case (cmd_head.op)
         tcce_pkg::OP_PUT:       col_nx = col_ff + 1'b1;
         tcce_pkg::OP_NEWLINE: begin
            col_nx  = '0;
            advance = 1'b1;
         end
         tcce_pkg::OP_RETURN:    col_nx = '0;
         tcce_pkg::OP_TAB:       col_nx = (col_ff + CW'(8)) & ~CW'(7);
         tcce_pkg::OP_BACKSPACE: col_nx = (col_ff != '0) ? col_ff - 1'b1 : col_ff;
         default:                col_nx = col_ff;
      endcase
      if (col_nx >= COLS_C) begin
         col_nx  = '0;
         advance = 1'b1;
      end
      row_inc = row_ff + 1'b1;
      scroll  = advance && (row_inc == ROWS_R);
      row_nx  = advance ? (scroll ? row_ff : row_inc) : row_ff;
   end

   assign rd_sum = SW'(cmd_head.cell_index) + SW'(top_base_ff);

   always_comb begin
      state_in       = state_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      row_base_in    = row_base_ff;
      top_base_in    = top_base_ff;
      color_in       = csr_write ? csr_data : color_ff;
      sweep_cnt_in   = sweep_cnt_ff;
      sweep_last_in  = sweep_last_ff;
      sweep_start_in = sweep_start_ff;
      sweep_color_in = sweep_color_ff;
      rd_valid_in    = rd_valid_ff;
      res_in         = res_ff;
      wr_en          = 1'b0;
      wr_addr        = sweep_start_ff + sweep_cnt_ff;
      wr_data        = {sweep_color_ff, tcce_pkg::CHAR_BLANK};
      rd_en          = 1'b0;
      rd_addr        = (rd_sum >= CELLS_S) ? AW'(rd_sum - CELLS_S) : AW'(rd_sum);
      rsp_push       = 1'b0;
      rsp_data       = res_ff;
      rsp_data.cell_data = rd_valid_ff ? rd_data : 16'd0;

      unique case (state_ff)
         ST_INIT: begin
            wr_en        = 1'b1;
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_pop) begin
               rd_valid_in         = 1'b0;
               res_in.cell_data    = 16'd0;
               res_in.scrolled     = 1'b0;
               state_in            = ST_RESPOND;
               case (cmd_head.op)
                  tcce_pkg::OP_CLEAR: begin
                     col_in         = '0;
                     row_in         = '0;
                     row_base_in    = '0;
                     top_base_in    = '0;
                     sweep_cnt_in   = '0;
                     sweep_start_in = '0;
                     sweep_last_in  = AW'(CELLS - 1);
                     sweep_color_in = color_ff;
                     state_in       = ST_SWEEP;
                  end
                  tcce_pkg::OP_READ: begin
                     rd_en       = 1'b1;
                     rd_valid_in = (SW'(cmd_head.cell_index) < CELLS_S);
                  end
                  tcce_pkg::OP_NONE: begin
                  end
                  default: begin
                     if (cmd_head.op == tcce_pkg::OP_PUT) begin
                        wr_en   = 1'b1;
                        wr_addr = row_base_ff + AW'(col_ff);
                        wr_data = {color_ff, cmd_head.char_code};
                     end
                     if (cmd_head.op == tcce_pkg::OP_BACKSPACE && col_ff != '0) begin
                        wr_en   = 1'b1;
                        wr_addr = row_base_ff + AW'(col_ff - 1'b1);
                        wr_data = {color_ff, tcce_pkg::CHAR_BLANK};
                     end
                     col_in = col_nx;
                     row_in = row_nx;
                     if (advance) begin
                        row_base_in = next_row_start(row_base_ff);
                     end
                     if (scroll) begin
                        // advance the top row and blank the new bottom row
                        top_base_in     = next_row_start(top_base_ff);
                        sweep_cnt_in    = '0;
                        sweep_start_in  = next_row_start(row_base_ff);
                        sweep_last_in   = AW'(COLUMNS - 1);
                        sweep_color_in  = color_ff;
                        res_in.scrolled = 1'b1;
                        state_in        = ST_SWEEP;
                     end
                  end
               endcase
               if (cmd_head.op == tcce_pkg::OP_CLEAR) begin
                  res_in.cursor_col = '0;
                  res_in.cursor_row = '0;
               end else if (cmd_head.op == tcce_pkg::OP_READ
                            || cmd_head.op == tcce_pkg::OP_NONE) begin
                  res_in.cursor_col = 7'(col_ff);
                  res_in.cursor_row = 5'(row_ff);
               end else begin
                  res_in.cursor_col = 7'(col_nx);
                  res_in.cursor_row = 5'(row_nx);
               end
            end
         end
         ST_SWEEP: begin
            wr_en        = 1'b1;
            sweep_cnt_in = sweep_cnt_ff + 1'b1;
            if (sweep_done) begin
               state_in = ST_RESPOND;
            end
         end
         ST_RESPOND: begin
            rsp_push = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         col_ff         <= '0;
         row_ff         <= '0;
         row_base_ff    <= '0;
         top_base_ff    <= '0;
         color_ff       <= tcce_pkg::RESET_COLOR;
         sweep_cnt_ff   <= '0;
         sweep_last_ff  <= AW'(CELLS - 1);
         sweep_start_ff <= '0;
         sweep_color_ff <= tcce_pkg::RESET_COLOR;
         rd_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         row_base_ff    <= row_base_in;
         top_base_ff    <= top_base_in;
         color_ff       <= color_in;
         sweep_cnt_ff   <= sweep_cnt_in;
         sweep_last_ff  <= sweep_last_in;
         sweep_start_ff <= sweep_start_in;
         sweep_color_ff <= sweep_color_in;
         rd_valid_ff    <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   tcce_ram #(
      .WIDTH(16),
      .DEPTH(CELLS)
   ) u_cells (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   `TCCE_ASSERT_SAME(a_pop_has_room, clock, reset, cmd_pop, !rsp_full)
   `TCCE_ASSERT_NEXT(a_respond_once, clock, reset, state_ff == ST_RESPOND, state_ff == ST_IDLE)
   `TCCE_ASSERT_SAME(a_cursor_range, clock, reset, 1'b1, col_ff < COLS_C && row_ff < ROWS_R)
   `TCCE_ASSERT_SAME(a_push_only_respond, clock, reset, rsp_push, !rsp_full)
   `TCCE_ASSERT_NEXT(a_init_holds_front, clock, reset, state_ff == ST_INIT && !sweep_done,
                     init_busy)

endmodule

// ----- rtl/text_console_cursor_engine.sv -----
// Top level of the text console cursor engine: ports, configuration
// register channel and result queue. Depends on tcce_pkg, tcce_front, tcce_back, tcce_queue.

// Character console with a ROWS x COLUMNS cell store (color high byte,
// character low byte) and a cursor. Commands enter a small queue and are
// executed one at a time by the back end: a printable character, return,
// tab, backspace, a newline without scrolling, a read or an unused kind
// goes from idle straight to the respond state. A step that scrolls first
// sweeps, since the store is a circular buffer of rows and only the new
// bottom row is blanked, one cell per cycle through the single write port.
// A clear sweeps the whole store in the same way. After reset the block
// blanks the whole store, one cell per cycle; req_full stays high during
// that pass while text color writes are taken. Each input transaction
// yields exactly one result transaction.
module text_console_cursor_engine #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [6:0]  rsp_cursor_col,
   output logic [4:0]  rsp_cursor_row,
   output logic [15:0] rsp_cell_data,
   output logic        rsp_scrolled,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_text_color
);

   tcce_pkg::cmd_type cmd_head;
   logic              cmd_valid, cmd_pop;
   logic              init_busy;
   logic              rq_push, rq_full;
   tcce_pkg::rsp_type rq_data, rsp_head;
   logic [$bits(tcce_pkg::rsp_type)-1:0] rq_head;

   assign csr_ready = 1'b1;

   tcce_front u_front (
      .clock          (clock),
      .reset          (reset),
      .hold           (init_busy),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .cmd_head       (cmd_head),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop)
   );

   tcce_back #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_head  (cmd_head),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_text_color),
      .rsp_full  (rq_full),
      .rsp_push  (rq_push),
      .rsp_data  (rq_data),
      .init_busy (init_busy)
   );

   tcce_queue #(
      .WIDTH($bits(tcce_pkg::rsp_type)),
      .DEPTH(tcce_pkg::RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (rq_data),
      .full      (rq_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rq_head)
   );

   assign rsp_head       = tcce_pkg::rsp_type'(rq_head);
   assign rsp_cursor_col = rsp_head.cursor_col;
   assign rsp_cursor_row = rsp_head.cursor_row;
   assign rsp_cell_data  = rsp_head.cell_data;
   assign rsp_scrolled   = rsp_head.scrolled;

endmodule

// ----- tb/tb_text_console_cursor_engine.sv -----
// Testbench for the text console cursor engine: directed and random traffic
// checked against a cycle-free shadow of the cell store, cursor and color.
// Depends on tcce_pkg and text_console_cursor_engine from the rtl folder.
module tb_text_console_cursor_engine;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   localparam logic [1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [6:0]  col;
      logic [4:0]  row;
      logic [15:0] cell_data;
      logic        scrolled;
   } console_reply_type;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_kind;
   logic [7:0]  req_char_code;
   logic [10:0] req_cell_index;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [6:0]  rsp_cursor_col;
   logic [4:0]  rsp_cursor_row;
   logic [15:0] rsp_cell_data;
   logic        rsp_scrolled;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_text_color;

   // Shadow of the screen state, advanced when a transaction is accepted.
   logic [15:0]       shadow_cells [CELL_COUNT];
   int unsigned       shadow_col;
   int unsigned       shadow_row;
   logic [7:0]        shadow_color;
   console_reply_type pending_replies [$];

   int mismatch_count;
   int send_idle_pct;
   int pop_idle_pct;

   text_console_cursor_engine #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_kind      (req_kind),
      .req_char_code (req_char_code),
      .req_cell_index(req_cell_index),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_cell_data (rsp_cell_data),
      .rsp_scrolled  (rsp_scrolled),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_text_color(csr_text_color)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Advance the shadow screen by one command and return the reply it gives.
   function automatic console_reply_type predict_console_step(input logic [1:0] kind,
                                                              input logic [7:0] ch,
                                                              input logic [10:0] idx);
      console_reply_type reply;
      int                i;
      reply = '0;
      case (kind)
         tcce_pkg::KIND_PUT: begin
            if (ch == tcce_pkg::CHAR_NEWLINE) begin
               shadow_col = 0;
               shadow_row++;
            end else if (ch == tcce_pkg::CHAR_RETURN) begin
               shadow_col = 0;
            end else if (ch == tcce_pkg::CHAR_TAB) begin
               shadow_col = (shadow_col + 8) & ~32'd7;
            end else if (ch == tcce_pkg::CHAR_BACKSPACE) begin
               if (shadow_col > 0) begin
                  shadow_col--;
                  shadow_cells[shadow_row * COLUMNS + shadow_col] =
                     {shadow_color, tcce_pkg::CHAR_BLANK};
               end
            end else begin
               shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_color, ch};
               shadow_col++;
            end
            if (shadow_col >= COLUMNS) begin
               shadow_col = 0;
               shadow_row++;
            end
            if (shadow_row >= ROWS) begin
               // shift every row up, blank the new bottom row
               for (i = 0; i < CELL_COUNT - COLUMNS; i++)
                  shadow_cells[i] = shadow_cells[i + COLUMNS];
               for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                  shadow_cells[i] = {shadow_color, tcce_pkg::CHAR_BLANK};
               shadow_row = ROWS - 1;
               reply.scrolled = 1'b1;
            end
         end
         tcce_pkg::KIND_CLEAR: begin
            for (i = 0; i < CELL_COUNT; i++)
               shadow_cells[i] = {shadow_color, tcce_pkg::CHAR_BLANK};
            shadow_col = 0;
            shadow_row = 0;
         end
         tcce_pkg::KIND_READ: begin
            if (idx < CELL_COUNT)
               reply.cell_data = shadow_cells[idx];
         end
         default: begin
         end
      endcase
      reply.col = shadow_col[6:0];
      reply.row = shadow_row[4:0];
      return reply;
   endfunction

   // Issue one command, holding it until the block takes it.
   task automatic send_item(input logic [1:0] kind, input logic [7:0] ch,
                            input logic [10:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_push <= 1'b0;
      end
      @(negedge clock);
      req_push       <= 1'b1;
      req_kind       <= kind;
      req_char_code  <= ch;
      req_cell_index <= idx;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      pending_replies.push_back(predict_console_step(kind, ch, idx));
   endtask

   // Drop the request line and hold until every predicted reply has come back.
   task automatic wait_for_replies(input int settle);
      @(negedge clock);
      req_push <= 1'b0;
      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_text_color(input logic [7:0] color);
      wait_for_replies(4);
      @(negedge clock);
      csr_valid      <= 1'b1;
      csr_text_color <= color;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      shadow_color = color;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Reply checker and random pop pacing.
   initial begin
      console_reply_type want;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            if (pending_replies.size() == 0) begin
               $error("reply transaction with no command outstanding");
               mismatch_count++;
            end else begin
               want = pending_replies.pop_front();
               if (rsp_cursor_col !== want.col) begin
                  $error("cursor_col: expected %0d, actual %0d", want.col, rsp_cursor_col);
                  mismatch_count++;
               end
               if (rsp_cursor_row !== want.row) begin
                  $error("cursor_row: expected %0d, actual %0d", want.row, rsp_cursor_row);
                  mismatch_count++;
               end
               if (rsp_cell_data !== want.cell_data) begin
                  $error("cell_data: expected 0x%04h, actual 0x%04h",
                         want.cell_data, rsp_cell_data);
                  mismatch_count++;
               end
               if (rsp_scrolled !== want.scrolled) begin
                  $error("scrolled: expected %0d, actual %0d", want.scrolled, rsp_scrolled);
                  mismatch_count++;
               end
            end
         end
         @(negedge clock);
         rsp_pop <= ($urandom_range(99) >= pop_idle_pct);
      end
   end

   task automatic test_reset_contents();
      send_item(tcce_pkg::KIND_READ, 8'h00, 11'd0);
      send_item(tcce_pkg::KIND_READ, 8'h00, 11'(CELL_COUNT - 1));
      send_item(tcce_pkg::KIND_READ, 8'h00, 11'(CELL_COUNT));
      send_item(tcce_pkg::KIND_READ, 8'hFF, 11'h7FF);
   endtask

   task automatic test_control_bytes();
      // column 0: no move, no blank
      send_item(tcce_pkg::KIND_PUT, tcce_pkg::CHAR_BACKSPACE, 11'd0);
      send_item(tcce_pkg::KIND_PUT, 8'h00, 11'd0);
      send_item(tcce_pkg::KIND_PUT, 8'hFF, 11'h7FF);
      send_item(tcce_pkg::KIND_PUT, 8'h41, 11'd0);
      send_item(tcce_pkg::KIND_PUT, tcce_pkg::CHAR_BACKSPACE, 11'd0);
      send_item(tcce_pkg::KIND_READ, 8'h00, 11'd1);
      send_item(tcce_pkg::KIND_READ, 8'h00, 11'd2);
      send_item(tcce_pkg::KIND_PUT, tcce_pkg::CHAR_TAB, 11'd0);
      send_item(tcce_pkg::KIND_PUT, tcce_pkg::CHAR_RETURN, 11'd0);
      send_item(tcce_pkg::KIND_PUT, tcce_pkg::CHAR_NEWLINE, 11'd0);
      send_item(KIND_UNUSED, 8'hFF, 11'h7FF);
      // last tab runs past the final column and wraps to the next row
      repeat (10) send_item(tcce_pkg::KIND_PUT, tcce_pkg::CHAR_TAB, 11'd0);
   endtask

   task automatic test_text_color();
      int at;
      write_text_color(8'hFF);
      at = shadow_row * COLUMNS + shadow_col;
      send_item(tcce_pkg::KIND_PUT, 8'h5A, 11'd0);
      send_item(tcce_pkg::KIND_READ, 8'h00, 11'(at));
      send_item(tcce_pkg::KIND_PUT, tcce_pkg::CHAR_BACKSPACE, 11'd0);
      send_item(tcce_pkg::KIND_READ, 8'h00, 11'(at));
      write_text_color(8'h00);
      send_item(tcce_pkg::KIND_CLEAR, 8'h00, 11'd0);
      send_item(tcce_pkg::KIND_READ, 8'h00, 11'd0);
      send_item(tcce_pkg::KIND_READ, 8'h00, 11'(CELL_COUNT - 1));
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int pop_pct,
                                      input logic [7:0] color);
      int          n;
      int          pick;
      int          sub;
      logic [1:0]  kind;
      logic [7:0]  ch;
      logic [10:0] idx;
      write_text_color(color);
      send_idle_pct = send_pct;
      pop_idle_pct  = pop_pct;
      for (n = 0; n < count; n++) begin
         // drain halfway through and switch color on an idle block
         if (n == count / 2)
            write_text_color(8'($urandom_range(255)));
         pick = $urandom_range(399);
         sub  = $urandom_range(99);
         ch   = 8'($urandom_range(255));
         idx  = 11'($urandom_range(2047));
         if (pick == 0) begin
            kind = tcce_pkg::KIND_CLEAR;
         end else if (pick < 300) begin
            kind = tcce_pkg::KIND_PUT;
            if (sub < 8)
               ch = tcce_pkg::CHAR_NEWLINE;
            else if (sub < 12)
               ch = tcce_pkg::CHAR_RETURN;
            else if (sub < 18)
               ch = tcce_pkg::CHAR_TAB;
            else if (sub < 25)
               ch = tcce_pkg::CHAR_BACKSPACE;
         end else if (pick < 380) begin
            kind = tcce_pkg::KIND_READ;
            if (sub < 15)
               idx = 11'($urandom_range(2047, CELL_COUNT));
            else if (sub < 60)
               idx = 11'(shadow_row * COLUMNS + $urandom_range(COLUMNS - 1));
            else
               idx = 11'($urandom_range(CELL_COUNT - 1));
         end else begin
            kind = KIND_UNUSED;
         end
         send_item(kind, ch, idx);
      end
   endtask

   initial begin
      int i;
      reset          = 1'b1;
      req_push       = 1'b0;
      req_kind       = tcce_pkg::KIND_PUT;
      req_char_code  = 8'h00;
      req_cell_index = 11'd0;
      csr_valid      = 1'b0;
      csr_text_color = tcce_pkg::RESET_COLOR;
      mismatch_count = 0;
      send_idle_pct  = 12;
      pop_idle_pct   = 59;
      shadow_color   = tcce_pkg::RESET_COLOR;
      shadow_col     = 0;
      shadow_row     = 0;
      for (i = 0; i < CELL_COUNT; i++)
         shadow_cells[i] = {tcce_pkg::RESET_COLOR, tcce_pkg::CHAR_BLANK};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_contents();
      test_control_bytes();
      test_text_color();
      test_random_traffic(530, 12, 59, 8'hFF);
      test_random_traffic(530, 59, 12, 8'h00);
      test_random_traffic(530, 0, 0, 8'($urandom_range(255)));
      wait_for_replies(CELL_COUNT + 10);

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // Generous time bound, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/tcce_queue.sv
rtl/tcce_front.sv
rtl/tcce_back.sv
rtl/text_console_cursor_engine.sv
tb/tb_text_console_cursor_engine.sv
